>>> sv/bfcr_pkg.sv
// ----------------------------------------------------------------------------
// bfcr_pkg: shared types, constants and function of the frame checker
// Register indexes, result codes, the configuration bundle and the CRC-8 step.
// ----------------------------------------------------------------------------
package bfcr_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 4096;

	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned MINBUF_W = 13;
	localparam int unsigned CFG_W    = 13;
	localparam int unsigned CFGIDX_W = 2;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	// layout: head at 0, address at 1, length at 2, three bytes of overhead
	localparam int unsigned POS_LEN  = 2;
	localparam int unsigned OVERHEAD = 3;

	localparam logic [CFGIDX_W-1:0] REG_HEAD_BYTE  = 2'd0;
	localparam logic [CFGIDX_W-1:0] REG_MIN_LENGTH = 2'd1;
	localparam logic [CFGIDX_W-1:0] REG_MAX_LENGTH = 2'd2;
	localparam logic [CFGIDX_W-1:0] REG_MIN_BUFFER = 2'd3;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_MORE    = 2'd1,
		ST_DISCARD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SRCH_NONE  = 2'd0,
		SRCH_FROM0 = 2'd1,
		SRCH_FROM1 = 2'd2
	} search_t;

	typedef struct packed {
		logic [7:0]          head_byte;
		logic [7:0]          min_length;
		logic [7:0]          max_length;
		logic [MINBUF_W-1:0] min_buffer;
	} cfg_t;

	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic                resync;
	} result_t;

	// CRC-8, poly 0x07, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int j = 0; j < 8; j++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/bfcr_scan.sv
// ----------------------------------------------------------------------------
// bfcr_scan: per-buffer scan state and end-of-buffer verdict
// Tracks position, CRC, length, head positions and the sticky resync flag;
// on the last word produces the verdict and clears the buffer state.
// ----------------------------------------------------------------------------
module bfcr_scan #(
	parameter int unsigned BUFFER_BYTES = bfcr_pkg::BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  bfcr_pkg::cfg_t    cfg,
	output bfcr_pkg::result_t result
);
	import bfcr_pkg::*;

	localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned CMP_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

	logic [POS_W-1:0] pos_q, pos_nx;
	logic [7:0]       crc_q, crc_nx;
	logic [7:0]       len_q, len_nx;
	logic             first_head_q, first_head_nx;
	logic             seen_q, seen_nx;
	logic [POS_W-1:0] off_q, off_nx;
	logic             crc_ok_q, crc_ok_nx;
	logic             resync_q, resync_nx;

	logic [CMP_W-1:0] pos_c, n_c, len_end_c, len_c, frame_c;
	logic             is_head;
	search_t          search;
	status_t          status_v;
	logic [CMP_W-1:0] count_v;

	assign is_head   = (data_byte == cfg.head_byte);
	assign pos_c     = CMP_W'(pos_q);
	assign len_c     = CMP_W'(len_nx);
	assign len_end_c = len_c + CMP_W'(POS_LEN);
	assign frame_c   = len_c + CMP_W'(OVERHEAD);
	assign n_c       = CMP_W'(pos_nx);

	// byte update
	always_comb begin
		pos_nx        = pos_q;
		crc_nx        = crc_q;
		len_nx        = len_q;
		first_head_nx = first_head_q;
		seen_nx       = seen_q;
		off_nx        = off_q;
		crc_ok_nx     = crc_ok_q;
		if (pos_q < POS_W'(BUFFER_BYTES)) begin
			pos_nx = pos_q + POS_W'(1);
			if (pos_q == '0) begin
				first_head_nx = is_head;
			end else if (!seen_q && is_head) begin
				seen_nx = 1'b1;
				off_nx  = pos_q;
			end
			if (pos_q == POS_W'(POS_LEN)) begin
				len_nx = data_byte;
			end
			if (pos_q >= POS_W'(POS_LEN)) begin
				// CRC covers the length byte and payload; the byte after is the check
				if (pos_c < len_end_c) begin
					crc_nx = crc8_byte(crc_q, data_byte);
				end else if (pos_c == len_end_c) begin
					crc_ok_nx = (crc_q == data_byte);
				end
			end
		end
	end

	// verdict on the last word
	always_comb begin
		search    = SRCH_NONE;
		status_v  = ST_MORE;
		count_v   = '0;
		resync_nx = resync_q;
		if (n_c < CMP_W'(cfg.min_buffer)) begin
			search = SRCH_NONE;
		end else if (resync_q || !first_head_nx) begin
			search = SRCH_FROM0;
		end else if (n_c < CMP_W'(OVERHEAD)) begin
			search = SRCH_NONE;
		end else if (len_nx < cfg.min_length || len_nx > cfg.max_length) begin
			search = SRCH_FROM1;
		end else if (n_c < frame_c) begin
			search = SRCH_NONE;
		end else if (!crc_ok_nx) begin
			search = SRCH_FROM1;
		end else begin
			status_v = ST_VALID;
			count_v  = frame_c;
		end

		case (search)
			SRCH_FROM0, SRCH_FROM1: begin
				status_v = ST_DISCARD;
				if (search == SRCH_FROM0 && first_head_nx) begin
					count_v   = '0;
					resync_nx = 1'b0;
				end else if (seen_nx) begin
					count_v   = CMP_W'(off_nx);
					resync_nx = 1'b0;
				end else begin
					count_v   = n_c;
					resync_nx = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.status = status_v;
	assign result.count  = count_v[COUNT_W-1:0];
	assign result.resync = resync_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			crc_q        <= '0;
			len_q        <= '0;
			first_head_q <= 1'b0;
			seen_q       <= 1'b0;
			off_q        <= '0;
			crc_ok_q     <= 1'b0;
			resync_q     <= 1'b0;
		end else if (en) begin
			if (last_byte) begin
				pos_q        <= '0;
				crc_q        <= '0;
				len_q        <= '0;
				first_head_q <= 1'b0;
				seen_q       <= 1'b0;
				off_q        <= '0;
				crc_ok_q     <= 1'b0;
				resync_q     <= resync_nx;
			end else begin
				pos_q        <= pos_nx;
				crc_q        <= crc_nx;
				len_q        <= len_nx;
				first_head_q <= first_head_nx;
				seen_q       <= seen_nx;
				off_q        <= off_nx;
				crc_ok_q     <= crc_ok_nx;
			end
		end
	end

endmodule

>>> sv/bus_frame_check_resync_unit.sv
// ----------------------------------------------------------------------------
// bus_frame_check_resync_unit: framed-message checker with resync
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_we             cfg_index, cfg_data
//   in       in         in_valid/in_stall  data_byte, last_byte
//   out      out        out_valid/out_stall status, count, resync_after
//
// One word per cycle while in is not stalled: each word is registered in the input
// stage, scanned from there and, if it is the last word of a buffer, its verdict
// lands in the output register. The verdict is offered once it is in the output
// register; one word per cycle is sustained while out is not stalled. A stalled verdict
// holds the last word of the next buffer in the input stage; other words keep flowing.
// Reset clears all scan state, the resync flag and loads register defaults.
// ----------------------------------------------------------------------------
module bus_frame_check_resync_unit #(
	parameter int unsigned BUFFER_BYTES = bfcr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bfcr_pkg::CFGIDX_W-1:0]   cfg_index,
	input  logic [bfcr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [bfcr_pkg::COUNT_W-1:0]    count,
	output logic                            resync_after
);
	import bfcr_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               last_s1;
	logic               advance;
	result_t            res;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [COUNT_W-1:0] count_q;
	logic               resync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte  <= 8'd0;
			cfg_q.min_length <= 8'd1;
			cfg_q.max_length <= 8'd255;
			cfg_q.min_buffer <= MINBUF_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAD_BYTE:  cfg_q.head_byte  <= cfg_data[7:0];
				REG_MIN_LENGTH: cfg_q.min_length <= cfg_data[7:0];
				REG_MAX_LENGTH: cfg_q.max_length <= cfg_data[7:0];
				REG_MIN_BUFFER: cfg_q.min_buffer <= cfg_data[MINBUF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// a last word needs room in the output register; others always advance
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	bfcr_scan #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= res.status;
			count_q  <= res.count;
			resync_q <= res.resync;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign count        = count_q;
	assign resync_after = resync_q;

endmodule

>>> tb/tb_bus_frame_check_resync_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bus_frame_check_resync_unit: self-checking bench for the frame checker
// Streams well-formed, damaged, truncated and noisy buffers through the byte
// channel with random sender bursts and receiver stalls, predicts the verdict
// of every closed buffer and compares it field by field with the output.
// ----------------------------------------------------------------------------
module tb_bus_frame_check_resync_unit;
	import bfcr_pkg::*;

	localparam int unsigned BUF_BYTES    = BUFFER_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned PHASE_WORDS  = 170;
	localparam int unsigned RAND_PHASES  = 5;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFGIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          data_byte = '0;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [COUNT_W-1:0]  count;
	logic                resync_after;

	bus_frame_check_resync_unit #(
		.BUFFER_BYTES(BUF_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.count        (count),
		.resync_after (resync_after)
	);

	always #10 clk = ~clk;

	// register copy, reset values
	cfg_t cfg_m = '{head_byte: 8'h00, min_length: 8'd1, max_length: 8'd255, min_buffer: 13'd4};

	word_t       word_q[$];
	result_t     verdict_q[$];
	logic [7:0]  frame_q[$];
	int unsigned queued_words = 0;
	int unsigned accepted_words = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// scan state of the open buffer
	logic        resync_m = 1'b0;
	int unsigned pos_m = 0;
	logic [7:0]  crc_m = '0;
	logic [7:0]  len_m = '0;
	logic        head0_m = 1'b0;
	logic        head_later_m = 1'b0;
	int unsigned head_off_m = 0;
	logic        crc_ok_m = 1'b0;

	function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		repeat (8) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	task automatic predict_word(input logic [7:0] b, input logic fin);
		int unsigned n;
		int unsigned k;
		search_t     srch;
		result_t     r;
		// bytes beyond the buffer are dropped
		if (pos_m < BUF_BYTES) begin
			if (pos_m == 0) begin
				head0_m = (b == cfg_m.head_byte);
			end else if (!head_later_m && b == cfg_m.head_byte) begin
				head_later_m = 1'b1;
				head_off_m = pos_m;
			end
			if (pos_m == POS_LEN) begin
				len_m = b;
			end
			if (pos_m >= POS_LEN) begin
				k = pos_m - POS_LEN;
				if (k < len_m) begin
					crc_m = crc8_next(crc_m, b);
				end else if (k == len_m) begin
					crc_ok_m = (crc_m == b);
				end
			end
			pos_m++;
		end
		if (fin) begin
			n = pos_m;
			srch = SRCH_NONE;
			r.status = ST_MORE;
			r.count = '0;
			if (n >= cfg_m.min_buffer) begin
				if (resync_m || !head0_m) begin
					srch = SRCH_FROM0;
				end else if (n >= POS_LEN + 1) begin
					if (len_m < cfg_m.min_length || len_m > cfg_m.max_length) begin
						srch = SRCH_FROM1;
					end else if (n >= len_m + OVERHEAD) begin
						if (!crc_ok_m) begin
							srch = SRCH_FROM1;
						end else begin
							r.status = ST_VALID;
							r.count = COUNT_W'(len_m + OVERHEAD);
						end
					end
				end
			end
			if (srch != SRCH_NONE) begin
				r.status = ST_DISCARD;
				if (srch == SRCH_FROM0 && head0_m) begin
					r.count = '0;
					resync_m = 1'b0;
				end else if (head_later_m) begin
					r.count = COUNT_W'(head_off_m);
					resync_m = 1'b0;
				end else begin
					r.count = COUNT_W'(n);
					resync_m = 1'b1;
				end
			end
			r.resync = resync_m;
			verdict_q.push_back(r);
			pos_m = 0;
			crc_m = '0;
			len_m = '0;
			head0_m = 1'b0;
			head_later_m = 1'b0;
			head_off_m = 0;
			crc_ok_m = 1'b0;
		end
	endtask

	// sender: bursts of random length, random gaps between them
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		word_t w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_word(data_byte, last_byte);
				accepted_words++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 || word_q.size() == 0) begin
					if (gap_left != 0) begin
						gap_left--;
					end
					in_valid <= 1'b0;
				end else begin
					w = word_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= w.data;
					last_byte <= w.last;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	task automatic check_verdict();
		result_t e;
		if (verdict_q.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected word: expected none, got status %0d count %0d resync %0d",
				$time, status, count, resync_after);
		end else begin
			e = verdict_q.pop_front();
			if (status !== e.status) begin
				mismatches++;
				$display("%0t: status: expected %0d, got %0d", $time, e.status, status);
			end
			if (count !== e.count) begin
				mismatches++;
				$display("%0t: count: expected %0d, got %0d", $time, e.count, count);
			end
			if (resync_after !== e.resync) begin
				mismatches++;
				$display("%0t: resync_after: expected %0d, got %0d", $time, e.resync,
					resync_after);
			end
		end
	endtask

	// receiver: a randomly chosen stall mode drives out_stall
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_verdict();
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(16, 160);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((stall_left % 5) < 2);
			endcase
		end
	end

	task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		// junk above an 8-bit register must be ignored
		if (idx == REG_MIN_BUFFER) begin
			cfg_data <= CFG_W'(val);
		end else begin
			cfg_data <= {(CFG_W - 8)'($urandom), 8'(val)};
		end
		case (idx)
			REG_HEAD_BYTE:  cfg_m.head_byte = 8'(val);
			REG_MIN_LENGTH: cfg_m.min_length = 8'(val);
			REG_MAX_LENGTH: cfg_m.max_length = 8'(val);
			default:        cfg_m.min_buffer = MINBUF_W'(val);
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int unsigned hd, input int unsigned mn,
			input int unsigned mx, input int unsigned mb);
		write_reg(REG_HEAD_BYTE, hd);
		write_reg(REG_MIN_LENGTH, mn);
		write_reg(REG_MAX_LENGTH, mx);
		write_reg(REG_MIN_BUFFER, mb);
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (accepted_words != queued_words || verdict_q.size() != 0);
		// words that close no buffer may still be in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_noise(input int unsigned n, input bit allow_head);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (!allow_head && b == cfg_m.head_byte) begin
				b = ~b;
			end
			frame_q.push_back(b);
		end
	endtask

	task automatic add_frame(input logic [7:0] hd, input int unsigned len, input bit good);
		logic [7:0] crc;
		logic [7:0] b;
		crc = '0;
		frame_q.push_back(hd);
		frame_q.push_back(8'($urandom));
		if (len == 0) begin
			// zero length: the length byte is also the check byte
			frame_q.push_back(8'h00);
		end else begin
			b = 8'(len);
			for (int i = 0; i < len; i++) begin
				if (i != 0) begin
					b = 8'($urandom);
				end
				frame_q.push_back(b);
				crc = crc8_next(crc, b);
			end
			if (!good) begin
				crc ^= 8'($urandom_range(1, 255));
			end
			frame_q.push_back(crc);
		end
	endtask

	// hand over all but the last 'keep' bytes; keep 0 closes the buffer
	task automatic send_buffer(input int unsigned keep);
		word_t w;
		while (frame_q.size() > keep) begin
			w.data = frame_q.pop_front();
			w.last = (keep == 0 && frame_q.size() == 0);
			word_q.push_back(w);
			queued_words++;
		end
	endtask

	function automatic int unsigned pick_len();
		int unsigned lo;
		int unsigned hi;
		lo = cfg_m.min_length;
		hi = cfg_m.max_length;
		if (lo > hi) begin
			return $urandom_range(0, 30);
		end
		// keep most frames short
		if (hi - lo > 24 && $urandom_range(0, 9) != 0) begin
			hi = lo + 24;
		end
		return $urandom_range(lo, hi);
	endfunction

	task automatic add_random_buffer();
		int unsigned pick;
		int unsigned lo;
		int unsigned hi;
		int unsigned up;
		logic [7:0]  hd;
		pick = $urandom_range(0, 99);
		hd = cfg_m.head_byte;
		lo = cfg_m.min_length;
		hi = cfg_m.max_length;
		up = (hi + 20 > 255) ? 255 : hi + 20;
		if (pick < 40) begin
			add_frame(hd, pick_len(), 1'b1);
		end else if (pick < 50) begin
			add_frame(hd, pick_len(), 1'b1);
			add_noise($urandom_range(1, 8), 1'b1);
		end else if (pick < 58) begin
			add_frame(hd, pick_len(), 1'b1);
			repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
		end else if (pick < 68) begin
			add_frame(hd, pick_len(), 1'b0);
		end else if (pick < 73) begin
			if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 0)) begin
				add_frame(hd, $urandom_range(0, lo - 1), 1'b1);
			end else if (hi < 255) begin
				add_frame(hd, $urandom_range(hi + 1, up), 1'b1);
			end else begin
				add_frame(hd, pick_len(), 1'b1);
			end
		end else if (pick < 83) begin
			add_noise($urandom_range(1, 12), 1'($urandom_range(0, 1)));
		end else if (pick < 93) begin
			add_noise($urandom_range(1, 6), 1'b0);
			add_frame(hd, pick_len(), 1'b1);
		end else begin
			add_noise($urandom_range(1, 3), 1'b1);
		end
	endtask

	initial begin
		int unsigned hd;
		int unsigned mn;
		int unsigned mx;
		int unsigned mb;
		int unsigned phase_words;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: head 0x00, lengths 1..255, minimum buffer 4
		add_frame(8'h00, 1, 1'b1);
		send_buffer(0);
		frame_q.push_back(8'h00);
		send_buffer(0);
		add_noise(6, 1'b0);
		send_buffer(0);
		// resync pending, head sits at offset zero
		add_frame(8'h00, 5, 1'b1);
		send_buffer(0);
		add_frame(8'h00, 5, 1'b1);
		send_buffer(0);
		add_frame(8'h00, 4, 1'b0);
		add_noise(2, 1'b0);
		frame_q.push_back(8'h00);
		send_buffer(0);
		add_frame(8'h00, 3, 1'b0);
		send_buffer(0);
		add_frame(8'h00, 10, 1'b1);
		repeat (7) void'(frame_q.pop_back());
		send_buffer(0);
		add_frame(8'h00, 2, 1'b1);
		add_noise(3, 1'b1);
		send_buffer(0);
		wait_idle();

		set_config(8'hFF, 0, 255, 0);
		frame_q.push_back(8'hFF);
		send_buffer(0);
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h00);
		send_buffer(0);
		add_frame(8'hFF, 0, 1'b1);
		send_buffer(0);
		add_frame(8'hFF, 255, 1'b1);
		send_buffer(0);
		add_noise(5, 1'b0);
		frame_q.push_back(8'hFF);
		add_noise(4, 1'b1);
		send_buffer(0);
		add_frame(8'hFF, 7, 1'b1);
		send_buffer(0);
		// move the head marker with a buffer half received
		add_frame(8'hFF, 6, 1'b1);
		send_buffer(6);
		wait_idle();
		write_reg(REG_HEAD_BYTE, 8'h5A);
		send_buffer(0);
		wait_idle();

		// inverted length range
		set_config(8'hA5, 10, 5, 4096);
		add_frame(8'hA5, 7, 1'b1);
		send_buffer(0);
		wait_idle();
		write_reg(REG_MIN_BUFFER, 5);
		add_frame(8'hA5, 7, 1'b1);
		send_buffer(0);
		add_frame(8'hA5, 0, 1'b1);
		send_buffer(0);
		wait_idle();
		write_reg(REG_MIN_LENGTH, 4);
		write_reg(REG_MAX_LENGTH, 8);
		add_frame(8'hA5, 3, 1'b1);
		send_buffer(0);
		add_frame(8'hA5, 9, 1'b1);
		send_buffer(0);
		add_frame(8'hA5, 8, 1'b1);
		send_buffer(0);
		wait_idle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: hd = 0;
				1: hd = 255;
				default: hd = $urandom_range(0, 255);
			endcase
			mn = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
			case ($urandom_range(0, 3))
				0: mx = 255;
				1: mx = (mn + 30 > 255) ? 255 : mn + $urandom_range(0, 30);
				2: mx = $urandom_range(0, 255);
				default: mx = (mn + 10 > 255) ? 255 : mn + $urandom_range(0, 10);
			endcase
			mb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 6);
			set_config(hd, mn, mx, mb);
			// close a buffer left open by the previous phase
			send_buffer(0);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				add_random_buffer();
				phase_words += frame_q.size();
				if (phase_words >= PHASE_WORDS && frame_q.size() > 1 &&
						$urandom_range(0, 1) == 1) begin
					send_buffer($urandom_range(1, frame_q.size() - 1));
				end else begin
					send_buffer(0);
				end
			end
			wait_idle();
		end
		send_buffer(0);
		wait_idle();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
